// ===== design/wlm_pkg.sv =====
// ----------------------------------------------------------------------------
// wlm_pkg: shared types and constants of the wildcard line matcher
// Character codes, register decode, the configuration bundle, the control
// bundle of the window cells and the per-character compare.
// ----------------------------------------------------------------------------
package wlm_pkg;

   localparam int unsigned CHAR_W = 8;
   localparam logic [CHAR_W-1:0] WILDCARD_CHAR = 8'h3F;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

   localparam int unsigned COUNT_W = 32;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

   localparam int unsigned TEXT_W = 64;
   localparam int unsigned LENGTH_W = 4;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 64;

   // register select is byte address bit 3 (registers sit 8 bytes apart)
   localparam logic REG_PATTERN_TEXT = 1'b0;
   localparam logic REG_PATTERN_LENGTH = 1'b1;

   typedef struct packed {
      logic [TEXT_W-1:0] pattern_text;
      logic [LENGTH_W-1:0] pattern_length;
   } cfg_type;

   typedef struct packed {
      logic advance;
      logic flush;
   } cell_ctrl_type;

   function automatic logic char_match(input logic [CHAR_W-1:0] pattern_char,
                                       input logic [CHAR_W-1:0] text_char);
      char_match = (pattern_char == WILDCARD_CHAR) || (pattern_char == text_char);
   endfunction

endpackage

// ===== design/wlm_cell.sv =====
// ----------------------------------------------------------------------------
// wlm_cell: one stage of the text window
// Holds one earlier byte of the current line, hands it to the next cell on
// every non-newline transfer, compares it to the aligned pattern character.
// ----------------------------------------------------------------------------
module wlm_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  wlm_pkg::cell_ctrl_type       ctrl,
   input  logic [wlm_pkg::CHAR_W-1:0]   prev_char,
   input  logic [wlm_pkg::CHAR_W-1:0]   pattern_char,
   input  logic                         in_use,
   output logic [wlm_pkg::CHAR_W-1:0]   held_char,
   output logic                         char_hit
);
   import wlm_pkg::*;

   logic [CHAR_W-1:0] char_ff;
   logic [CHAR_W-1:0] char_in;

   always_comb begin
      char_in = char_ff;
      if (ctrl.advance) begin
         // a newline empties the window
         if (ctrl.flush) begin
            char_in = '0;
         end else begin
            char_in = prev_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= '0;
      end else begin
         char_ff <= char_in;
      end
   end

   assign held_char = char_ff;
   assign char_hit = !in_use || char_match(pattern_char, char_ff);

endmodule

// ===== design/wlm_csr.sv =====
// ----------------------------------------------------------------------------
// wlm_csr: configuration registers
// APB-style write and read of the pattern text and the pattern length.
// ----------------------------------------------------------------------------
module wlm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [wlm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [wlm_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [wlm_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output wlm_pkg::cfg_type                 cfg
);
   import wlm_pkg::*;

   logic [TEXT_W-1:0]   text_ff;
   logic [TEXT_W-1:0]   text_in;
   logic [LENGTH_W-1:0] length_ff;
   logic [LENGTH_W-1:0] length_in;
   logic                reg_sel;
   logic                wr_en;

   assign reg_sel = paddr[3];
   assign wr_en = psel && penable && pwrite;

   always_comb begin
      text_in = text_ff;
      length_in = length_ff;
      if (wr_en) begin
         if (reg_sel == REG_PATTERN_TEXT) begin
            text_in = pwdata[TEXT_W-1:0];
         end else begin
            length_in = pwdata[LENGTH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_ff <= '0;
         length_ff <= LENGTH_W'(1);
      end else begin
         text_ff <= text_in;
         length_ff <= length_in;
      end
   end

   always_comb begin
      if (reg_sel == REG_PATTERN_LENGTH) begin
         prdata = {{(CSR_DATA_W-LENGTH_W){1'b0}}, length_ff};
      end else begin
         prdata = text_ff;
      end
   end

   assign pready = 1'b1;
   assign cfg.pattern_text = text_ff;
   assign cfg.pattern_length = length_ff;

endmodule

// ===== design/wildcard_line_matcher.sv =====
// ----------------------------------------------------------------------------
// wildcard_line_matcher: streaming search for a pattern with '?' wildcards
// Finds every match, overlaps included, of a pattern of up to eight
// characters within the lines of a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one text byte per transfer; 0x0A ends a line.
//   rsp channel: one transfer per match, carrying the one-based line, the
//   zero-based start column and the matched bytes (first in lowest byte).
//   CSR port: pattern text at byte address 0, pattern length at 8; write
//   only while no byte is in flight.
// Timing:
//   A match shows on rsp in the cycle after the transfer of its last byte.
//   One byte per cycle is taken sustained while rsp is not stalled: the
//   window compare across the row of cells is done in the cycle a byte
//   arrives, and the result lands in a single output register.
// Reset: line 1, column 0, empty window, pattern text 0, pattern length 1.
// Stall: a waiting result holds in the output register; req_ready stays low
//   until rsp_ready takes it, and rises in the same cycle it is taken.
// ----------------------------------------------------------------------------
module wildcard_line_matcher #(
   parameter int unsigned PATTERN_MAX = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [wlm_pkg::CHAR_W-1:0]         req_text_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [wlm_pkg::COUNT_W-1:0]        rsp_line_number,
   output logic [wlm_pkg::COUNT_W-1:0]        rsp_start_column,
   output logic [wlm_pkg::TEXT_W-1:0]         rsp_matched_text,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [wlm_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [wlm_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [wlm_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import wlm_pkg::*;

   localparam int unsigned LEN_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam logic [LENGTH_W-1:0] MAX_LEN = LENGTH_W'(PATTERN_MAX);

   cfg_type             cfg;
   cell_ctrl_type       cell_ctrl;
   logic                accept;
   logic                is_newline;
   logic [LENGTH_W-1:0] len_eff;
   logic [LENGTH_W-1:0] len_eff_m1;
   logic [LEN_W-1:0]    len_m1;
   logic                hit;

   logic [CHAR_W-1:0]   window [PATTERN_MAX];
   logic [CHAR_W-1:0]   pattern_char [PATTERN_MAX];
   logic [LEN_W-1:0]    pat_idx [PATTERN_MAX];
   logic [LEN_W-1:0]    src_idx [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] in_use;
   logic [PATTERN_MAX-1:0] char_hits;
   logic [TEXT_W-1:0]   matched;

   logic [COUNT_W-1:0]  column_ff;
   logic [COUNT_W-1:0]  column_in;
   logic [COUNT_W-1:0]  line_ff;
   logic [COUNT_W-1:0]  line_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_line_ff;
   logic [COUNT_W-1:0]  rsp_column_ff;
   logic [TEXT_W-1:0]   rsp_text_ff;

   wlm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign is_newline = (req_text_byte == NEWLINE_CHAR);

   assign cell_ctrl.advance = accept;
   assign cell_ctrl.flush = is_newline;

   // clamp the programmed length into 1..PATTERN_MAX
   always_comb begin
      if (cfg.pattern_length == '0) begin
         len_eff = LENGTH_W'(1);
      end else if (cfg.pattern_length > MAX_LEN) begin
         len_eff = MAX_LEN;
      end else begin
         len_eff = cfg.pattern_length;
      end
   end

   assign len_eff_m1 = len_eff - LENGTH_W'(1);
   assign len_m1 = len_eff_m1[LEN_W-1:0];

   // position 0 is the incoming byte, position j the byte j back in the line
   assign window[0] = req_text_byte;

   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         pat_idx[j] = len_m1 - LEN_W'(j);
         in_use[j] = (LEN_W'(j) <= len_m1);
         pattern_char[j] = cfg.pattern_text[CHAR_W*pat_idx[j] +: CHAR_W];
      end
   end

   assign char_hits[0] = char_match(pattern_char[0], req_text_byte);

   for (genvar j = 1; j < PATTERN_MAX; j++) begin : g_cell
      wlm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .prev_char    (window[j-1]),
         .pattern_char (pattern_char[j]),
         .in_use       (in_use[j]),
         .held_char    (window[j]),
         .char_hit     (char_hits[j])
      );
   end

   // line up the window oldest byte first
   always_comb begin
      matched = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         src_idx[i] = len_m1 - LEN_W'(i);
         if (LEN_W'(i) <= len_m1) begin
            matched[CHAR_W*i +: CHAR_W] = window[src_idx[i]];
         end
      end
   end

   assign hit = !is_newline && (&char_hits) &&
                (column_ff >= COUNT_W'(len_m1));

   always_comb begin
      column_in = column_ff;
      line_in = line_ff;
      if (accept) begin
         if (is_newline) begin
            column_in = '0;
            if (line_ff != COUNT_MAX) begin
               line_in = line_ff + COUNT_W'(1);
            end
         end else if (column_ff != COUNT_MAX) begin
            column_in = column_ff + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = hit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         line_ff <= COUNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         column_ff <= column_in;
         line_ff <= line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the result payload only on a matching transfer
   always_ff @(posedge clock) begin
      if (accept && hit) begin
         rsp_line_ff <= line_ff;
         rsp_column_ff <= column_ff - COUNT_W'(len_m1);
         rsp_text_ff <= matched;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_line_number = rsp_line_ff;
   assign rsp_start_column = rsp_column_ff;
   assign rsp_matched_text = rsp_text_ff;

   a_newline_clears_column: assert property (@(posedge clock) disable iff (reset)
      accept && is_newline |=> column_ff == '0)
      else $error("column not cleared after newline");

   a_line_never_zero: assert property (@(posedge clock) disable iff (reset)
      accept |=> line_ff != '0)
      else $error("line count reached zero");

   a_result_behind_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_number <= line_ff) && (rsp_start_column <= column_ff))
      else $error("result lies ahead of the stream position");

endmodule

// ===== verif/wlm_match_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlm_match_checker: match predictor and comparator for the line matcher
// Watches the CSR port, the text byte channel and the match channel. Each
// byte transfer runs through a private copy of the window, column and line
// state, and any predicted match is queued. Match transfers are compared
// field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module wlm_match_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [wlm_pkg::CHAR_W-1:0]     req_text_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [wlm_pkg::COUNT_W-1:0]    rsp_line_number,
   input  logic [wlm_pkg::COUNT_W-1:0]    rsp_start_column,
   input  logic [wlm_pkg::TEXT_W-1:0]     rsp_matched_text,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [wlm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [wlm_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                          pready,
   input  logic                          end_check,
   output int unsigned                   pending_matches,
   output int unsigned                   mismatch_count
);
   import wlm_pkg::*;

   localparam int unsigned WINDOW_MAX = 8;
   localparam int unsigned HISTORY_DEPTH = WINDOW_MAX - 1;

   typedef struct packed {
      logic [COUNT_W-1:0] line_number;
      logic [COUNT_W-1:0] start_column;
      logic [TEXT_W-1:0]  matched_text;
   } match_type;

   match_type expected_matches[$];
   match_type got_match;
   logic [TEXT_W-1:0] pattern_text;
   logic [LENGTH_W-1:0] pattern_length;
   logic [CHAR_W-1:0] line_history [0:HISTORY_DEPTH-1];
   logic [COUNT_W-1:0] column_count;
   logic [COUNT_W-1:0] line_count;

   function automatic int unsigned active_length(input logic [LENGTH_W-1:0] raw);
      if (raw == 0) begin
         return 1;
      end
      if (raw > WINDOW_MAX) begin
         return WINDOW_MAX;
      end
      return 32'(raw);
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic predict_text_byte(input logic [CHAR_W-1:0] cur);
      int unsigned len;
      int unsigned back;
      int i;
      logic hit;
      logic [CHAR_W-1:0] text_char;
      logic [CHAR_W-1:0] pattern_char;
      match_type m;
      if (cur == NEWLINE_CHAR) begin
         for (i = 0; i < HISTORY_DEPTH; i++) begin
            line_history[i] = '0;
         end
         column_count = '0;
         if (line_count != COUNT_MAX) begin
            line_count++;
         end
      end else begin
         len = active_length(pattern_length);
         hit = (column_count >= len - 1);
         m = '0;
         for (i = 0; i < len; i++) begin
            back = len - 1 - i;
            text_char = (back == 0) ? cur : line_history[back - 1];
            pattern_char = pattern_text[CHAR_W*i +: CHAR_W];
            if (pattern_char != WILDCARD_CHAR && pattern_char != text_char) begin
               hit = 1'b0;
            end
            m.matched_text[CHAR_W*i +: CHAR_W] = text_char;
         end
         if (hit) begin
            m.line_number = line_count;
            m.start_column = column_count - (len - 1);
            expected_matches = {expected_matches, m};
         end
         for (i = HISTORY_DEPTH - 1; i > 0; i--) begin
            line_history[i] = line_history[i - 1];
         end
         line_history[0] = cur;
         if (column_count != COUNT_MAX) begin
            column_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pattern_text = '0;
         pattern_length = LENGTH_W'(1);
         for (int k = 0; k < HISTORY_DEPTH; k++) begin
            line_history[k] = '0;
         end
         column_count = '0;
         line_count = 1;
         expected_matches.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[3] == REG_PATTERN_TEXT) begin
               pattern_text = pwdata[TEXT_W-1:0];
            end else begin
               pattern_length = pwdata[LENGTH_W-1:0];
            end
         end
         // a match leaves through the output register after its byte was taken, so compare before predicting
         if (rsp_valid && rsp_ready) begin
            if (expected_matches.size() == 0) begin
               report_mismatch($sformatf("unexpected match line %0d column %0d text %h",
                                         rsp_line_number, rsp_start_column,
                                         rsp_matched_text));
            end else begin
               got_match = expected_matches.pop_front();
               if (rsp_line_number !== got_match.line_number) begin
                  report_mismatch($sformatf("line_number got %0d want %0d",
                                            rsp_line_number, got_match.line_number));
               end
               if (rsp_start_column !== got_match.start_column) begin
                  report_mismatch($sformatf("start_column got %0d want %0d",
                                            rsp_start_column, got_match.start_column));
               end
               if (rsp_matched_text !== got_match.matched_text) begin
                  report_mismatch($sformatf("matched_text got %h want %h",
                                            rsp_matched_text, got_match.matched_text));
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_text_byte(req_text_byte);
         end
         if (end_check && expected_matches.size() != 0) begin
            report_mismatch($sformatf("%0d expected matches never arrived",
                                      expected_matches.size()));
            expected_matches.delete();
         end
      end
      pending_matches = expected_matches.size();
   end

endmodule

// ===== verif/wildcard_line_matcher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_line_matcher_tb: stimulus and verdict for the line matcher
// Programs patterns of every length over the CSR port, streams text bytes
// holding planted pattern instances, newlines and noise, and stalls both
// channels at random in the first two of three phases. The checker beside
// the block predicts every match and counts mismatches.
// ----------------------------------------------------------------------------
module wildcard_line_matcher_tb;
   import wlm_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_PATTERN_TEXT = {REG_PATTERN_TEXT, 3'b000};
   localparam logic [CSR_ADDR_W-1:0] ADDR_PATTERN_LENGTH = {REG_PATTERN_LENGTH, 3'b000};
   localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_B = 8'h62;
   localparam int unsigned WINDOW_MAX = 8;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned DRAIN_LIMIT = 20000;
   localparam int unsigned BYTES_PER_PHASE = 255;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CHAR_W-1:0] req_text_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [COUNT_W-1:0] rsp_line_number;
   logic [COUNT_W-1:0] rsp_start_column;
   logic [TEXT_W-1:0] rsp_matched_text;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;
   logic end_check = 1'b0;

   int unsigned send_idle_pct = 15;
   int unsigned recv_stall_pct = 87;
   int unsigned bytes_sent = 0;
   int unsigned pending_matches;
   int unsigned mismatch_count;

   wildcard_line_matcher u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_number  (rsp_line_number),
      .rsp_start_column (rsp_start_column),
      .rsp_matched_text (rsp_matched_text),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   wlm_match_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_number  (rsp_line_number),
      .rsp_start_column (rsp_start_column),
      .rsp_matched_text (rsp_matched_text),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pready           (pready),
      .end_check        (end_check),
      .pending_matches  (pending_matches),
      .mismatch_count   (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL wildcard_line_matcher");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_text_byte(input logic [CHAR_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= value;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   // drop valid, let every queued match drain, then cover the output register
   task automatic wait_idle();
      int unsigned n;
      req_valid <= 1'b0;
      for (n = 0; pending_matches != 0 && n < DRAIN_LIMIT; n++) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [TEXT_W-1:0] text,
                            input logic [LENGTH_W-1:0] raw_len);
      wait_idle();
      csr_write(ADDR_PATTERN_TEXT, text);
      csr_write(ADDR_PATTERN_LENGTH, CSR_DATA_W'(raw_len));
   endtask

   function automatic logic [CHAR_W-1:0] pick_pattern_char();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 35) begin
         return CHAR_A;
      end
      if (r < 55) begin
         return CHAR_B;
      end
      if (r < 80) begin
         return WILDCARD_CHAR;
      end
      if (r < 84) begin
         return NEWLINE_CHAR;
      end
      return CHAR_W'($urandom_range(255));
   endfunction

   function automatic logic [CHAR_W-1:0] pick_text_char();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 40) begin
         return CHAR_A;
      end
      if (r < 75) begin
         return CHAR_B;
      end
      if (r < 83) begin
         return NEWLINE_CHAR;
      end
      return CHAR_W'($urandom_range(255));
   endfunction

   // plant pattern instances among noise so that most stretches hit
   task automatic run_random_segment(input int unsigned n_bytes);
      logic [TEXT_W-1:0] text;
      logic [LENGTH_W-1:0] raw_len;
      logic [CHAR_W-1:0] ch;
      int unsigned eff_len;
      int unsigned start;
      int unsigned i;
      for (i = 0; i < WINDOW_MAX; i++) begin
         text[CHAR_W*i +: CHAR_W] = pick_pattern_char();
      end
      if ($urandom_range(99) < 80) begin
         raw_len = LENGTH_W'($urandom_range(WINDOW_MAX, 1));
      end else begin
         raw_len = LENGTH_W'($urandom_range(15, 0));
      end
      eff_len = (raw_len == 0) ? 1 : ((raw_len > WINDOW_MAX) ? WINDOW_MAX : raw_len);
      configure(text, raw_len);
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         if ($urandom_range(99) < 35) begin
            for (i = 0; i < eff_len; i++) begin
               ch = text[CHAR_W*i +: CHAR_W];
               if (ch == WILDCARD_CHAR) begin
                  ch = pick_text_char();
               end
               send_text_byte(ch);
            end
         end else begin
            send_text_byte(pick_text_char());
         end
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned phase_start;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset pattern is a single zero byte
      send_text_byte(8'h00);
      send_text_byte(8'hFF);
      send_text_byte(NEWLINE_CHAR);
      send_text_byte(8'h00);

      // all wildcards, raw length above the window
      configure({8{WILDCARD_CHAR}}, 4'hF);
      send_text_byte(8'hFF);
      send_text_byte(8'h00);
      send_text_byte(8'h80);
      send_text_byte(8'h7F);
      send_text_byte(8'h01);
      send_text_byte(8'hFE);
      send_text_byte(WILDCARD_CHAR);
      send_text_byte(8'h55);

      // a newline in the pattern never matches
      configure({48'hFFFF_FFFF_FFFF, NEWLINE_CHAR, WILDCARD_CHAR}, 4'd2);
      send_text_byte(CHAR_A);
      send_text_byte(NEWLINE_CHAR);
      send_text_byte(CHAR_A);

      // raw length zero acts as one
      configure({48'h0, CHAR_A, CHAR_A}, 4'd0);
      send_text_byte(CHAR_A);
      send_text_byte(CHAR_A);

      // overlapping hits
      configure({48'h0, CHAR_A, CHAR_A}, 4'd2);
      send_text_byte(CHAR_A);
      send_text_byte(CHAR_A);
      send_text_byte(CHAR_A);

      configure(64'h0, 4'd8);
      send_text_byte(NEWLINE_CHAR);

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 15;
               recv_stall_pct = 87;
            end
            1: begin
               send_idle_pct = 87;
               recv_stall_pct = 15;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
            run_random_segment($urandom_range(60, 20));
         end
      end

      wait_idle();
      end_check <= 1'b1;
      @(negedge clock);
      end_check <= 1'b0;
      @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS wildcard_line_matcher");
      end else begin
         $display("FAIL wildcard_line_matcher");
      end
      $finish;
   end

endmodule
